// ----- sv/ctb_pkg.sv -----
// ctb_pkg: shared types, constants and operation codes of the countdown timer bank
// used by ctb_ctrl, ctb_datapath and countdown_timer_bank_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctb_pkg;

  // bank geometry
  localparam int NUM_TIMERS = 16;
  localparam int COUNT_BITS = 24;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // field widths
  localparam int OP_W    = 3;
  localparam int ID_W    = 4;
  localparam int MS_W    = 22;
  localparam int ENT_W   = 16;
  localparam int TYPE_W  = 8;
  localparam int FPS_W   = 10;

  // frames = fps * ms / 1000
  localparam int PROD_W    = FPS_W + MS_W;
  localparam int DIVISOR   = 1000;
  localparam logic [PROD_W-1:0] COUNT_MAX = PROD_W'((64'd1 << COUNT_BITS) - 64'd1);

  // divide by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38,
  // exact for every 32-bit product
  localparam int RECIP_W   = 29;
  localparam int DIV_SHIFT = 38;
  localparam int MULQ_W    = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  localparam logic [FPS_W-1:0] FPS_RESET = FPS_W'(60);

  // result kinds
  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_PAUSE   = 3'd4,
    OP_UNPAUSE = 3'd5
  } op_e;

  // timeout message kept per slot
  typedef struct packed {
    logic [ENT_W-1:0]  owner;
    logic [TYPE_W-1:0] kind_of_timeout;
    logic              sub_mark;
  } msg_t;

  // one result beat
  typedef struct packed {
    logic              result_kind;
    logic [ID_W-1:0]   slot_id;
    logic              create_ok;
    msg_t              msg;
    logic              last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic ptr_clr;
    logic ptr_inc;
    logic apply_op;
    logic tick_step;
    logic flush;
    logic mul;
    logic div_step;
    logic reply;
    logic reply_ok;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            last_slot;
    logic            free_hit;
    logic            tick_fire;
    logic            pend_v;
    logic            out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/ctb_datapath.sv -----
// ctb_datapath: timer counts, running and free flags, message store, frame
// divider, pending expiry and output register; depends on ctb_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctb_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ctb_pkg::FPS_W-1:0]   cfg_wdata_i,
  input  wire logic [ctb_pkg::OP_W-1:0]    operation_i,
  input  wire logic [ctb_pkg::ID_W-1:0]    timer_id_i,
  input  wire logic [ctb_pkg::MS_W-1:0]    time_ms_i,
  input  wire logic [ctb_pkg::ENT_W-1:0]   entity_i,
  input  wire logic [ctb_pkg::TYPE_W-1:0]  timeout_type_i,
  input  wire logic                        is_subtimer_i,
  input  wire ctb_pkg::cmd_t               cmd_i,
  output ctb_pkg::stat_t                   stat_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output ctb_pkg::result_t                 out_res_o
);

  // configuration
  logic [ctb_pkg::FPS_W-1:0] fps_q;

  // latched request
  logic [ctb_pkg::OP_W-1:0]  op_q;
  logic                      id_ok_q;
  logic [ctb_pkg::MS_W-1:0]  ms_q;
  ctb_pkg::msg_t             new_msg_q;
  logic [ctb_pkg::SLOT_W-1:0] ptr_q;

  // timer state
  logic [ctb_pkg::COUNT_BITS-1:0] cnt_q [ctb_pkg::NUM_TIMERS];
  logic [ctb_pkg::NUM_TIMERS-1:0] run_q;
  logic [ctb_pkg::NUM_TIMERS-1:0] free_q;
  ctb_pkg::msg_t                  msg_q [ctb_pkg::NUM_TIMERS];

  // divider
  logic [ctb_pkg::PROD_W-1:0]     prod_q;
  logic [ctb_pkg::MULQ_W-1:0]     recip_prod;
  logic [ctb_pkg::COUNT_BITS-1:0] cnt_load;

  // result staging
  ctb_pkg::result_t pend_q, out_q, out_d, expiry;
  logic             pend_v_q, out_v_q, out_v_d, out_load;

  // slot read at the pointer
  logic [ctb_pkg::COUNT_BITS-1:0] cnt_rd;
  logic                           run_rd, tick_fire, out_free;

  assign cnt_rd    = cnt_q[ptr_q];
  assign run_rd    = run_q[ptr_q];
  assign tick_fire = run_rd &&
                     (cnt_rd == '0 || cnt_rd == ctb_pkg::COUNT_BITS'(1));
  assign out_free  = !out_v_q || out_ready_i;

  // division by the constant as a multiply by its rounded-up reciprocal
  assign recip_prod = ctb_pkg::MULQ_W'(prod_q) * ctb_pkg::MULQ_W'(ctb_pkg::DIV_RECIP);

  // saturate the frame count
  assign cnt_load = (prod_q > ctb_pkg::COUNT_MAX)
                    ? ctb_pkg::COUNT_MAX[ctb_pkg::COUNT_BITS-1:0]
                    : prod_q[ctb_pkg::COUNT_BITS-1:0];

  // expiry beat for the slot under the pointer
  always_comb begin
    expiry             = '0;
    expiry.result_kind = ctb_pkg::KIND_EXPIRY;
    expiry.slot_id     = ctb_pkg::ID_W'(ptr_q);
    expiry.create_ok   = 1'b0;
    expiry.msg         = msg_q[ptr_q];
    expiry.last        = 1'b0;
  end

  // output register load
  always_comb begin
    out_load = 1'b0;
    out_d    = out_q;
    if (cmd_i.tick_step && tick_fire && pend_v_q) begin
      out_load = 1'b1;
      out_d    = pend_q;
      out_d.last = 1'b0;
    end else if (cmd_i.flush) begin
      out_load = 1'b1;
      out_d    = pend_q;
      out_d.last = 1'b1;
    end else if (cmd_i.reply) begin
      out_load          = 1'b1;
      out_d             = '0;
      out_d.result_kind = ctb_pkg::KIND_CREATE;
      out_d.slot_id     = cmd_i.reply_ok ? ctb_pkg::ID_W'(ptr_q) : '0;
      out_d.create_ok   = cmd_i.reply_ok;
      out_d.last        = 1'b1;
    end
    out_v_d = out_load || (out_v_q && !out_ready_i);
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q <= ctb_pkg::FPS_RESET;
    end else if (cfg_we_i) begin
      fps_q <= cfg_wdata_i;
    end
  end

  // request capture and slot pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      op_q    <= '0;
      id_ok_q <= 1'b0;
    end else if (cmd_i.capture) begin
      ptr_q   <= ctb_pkg::SLOT_W'(timer_id_i);
      op_q    <= operation_i;
      id_ok_q <= (32'(timer_id_i) < ctb_pkg::NUM_TIMERS);
    end else if (cmd_i.ptr_clr) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + ctb_pkg::SLOT_W'(1);
    end
  end

  // create payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ms_q                      <= time_ms_i;
      new_msg_q.owner           <= entity_i;
      new_msg_q.kind_of_timeout <= timeout_type_i;
      new_msg_q.sub_mark        <= is_subtimer_i;
    end
  end

  // product, then quotient in place
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ctb_pkg::PROD_W'(fps_q) * ctb_pkg::PROD_W'(ms_q);
    end else if (cmd_i.div_step) begin
      prod_q <= ctb_pkg::PROD_W'(recip_prod >> ctb_pkg::DIV_SHIFT);
    end
  end

  // timer counts, running and free flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ctb_pkg::NUM_TIMERS; i++) begin
        cnt_q[i] <= '0;
      end
      run_q  <= '0;
      free_q <= '1;
    end else if (cmd_i.tick_step) begin
      if (run_rd && cnt_rd != '0) begin
        cnt_q[ptr_q] <= cnt_rd - ctb_pkg::COUNT_BITS'(1);
      end
      if (tick_fire) begin
        run_q[ptr_q] <= 1'b0;
      end
    end else if (cmd_i.reply && cmd_i.reply_ok) begin
      cnt_q[ptr_q]  <= cnt_load;
      run_q[ptr_q]  <= 1'b1;
      free_q[ptr_q] <= 1'b0;
    end else if (cmd_i.apply_op && id_ok_q) begin
      unique case (op_q)
        ctb_pkg::OP_START: begin
          if (cnt_rd != '0) begin
            run_q[ptr_q] <= 1'b1;
          end
        end
        ctb_pkg::OP_STOP: begin
          run_q[ptr_q]  <= 1'b0;
          free_q[ptr_q] <= 1'b1;
        end
        ctb_pkg::OP_PAUSE: begin
          run_q[ptr_q] <= 1'b0;
        end
        ctb_pkg::OP_UNPAUSE: begin
          run_q[ptr_q] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // message store, written on a successful create
  always_ff @(posedge clk_i) begin
    if (cmd_i.reply && cmd_i.reply_ok) begin
      msg_q[ptr_q] <= new_msg_q;
    end
  end

  // pending expiry, held back until the next one or the end of the walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.tick_step && tick_fire) begin
      pend_v_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_step && tick_fire) begin
      pend_q <= expiry;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  // status to the controller
  always_comb begin
    stat_o           = '0;
    stat_o.op        = op_q;
    stat_o.last_slot = (ptr_q == ctb_pkg::SLOT_W'(ctb_pkg::NUM_TIMERS - 1));
    stat_o.free_hit  = free_q[ptr_q];
    stat_o.tick_fire = tick_fire;
    stat_o.pend_v    = pend_v_q;
    stat_o.out_free  = out_free;
  end

endmodule

`default_nettype wire

// ----- sv/ctb_ctrl.sv -----
// ctb_ctrl: state machine that sequences tick walks, creates and flag updates
// over ctb_datapath; depends on ctb_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ctb_pkg::stat_t stat_i,
  output ctb_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_REPLY = 3'd7;

  logic [2:0]                      state_q, state_d;
  logic                            ok_q, ok_d;
  logic                            tick_stall;

  // a second expiry cannot be staged while the output is still full
  assign tick_stall = stat_i.tick_fire && stat_i.pend_v && !stat_i.out_free;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ok_d       = ok_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.op)
          ctb_pkg::OP_TICK: begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = S_TICK;
          end
          ctb_pkg::OP_CREATE: begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = S_FIND;
          end
          ctb_pkg::OP_START, ctb_pkg::OP_STOP,
          ctb_pkg::OP_PAUSE, ctb_pkg::OP_UNPAUSE: begin
            cmd_o.apply_op = 1'b1;
            state_d        = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_TICK: begin
        if (!tick_stall) begin
          cmd_o.tick_step = 1'b1;
          if (stat_i.last_slot) begin
            state_d = S_FLUSH;
          end else begin
            cmd_o.ptr_inc = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!stat_i.pend_v) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_FIND: begin
        if (stat_i.free_hit) begin
          state_d = S_MUL;
        end else if (stat_i.last_slot) begin
          ok_d    = 1'b0;
          state_d = S_REPLY;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        ok_d           = 1'b1;
        state_d        = S_REPLY;
      end
      S_REPLY: begin
        if (stat_i.out_free) begin
          cmd_o.reply    = 1'b1;
          cmd_o.reply_ok = ok_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ok_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      ok_q      <= ok_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/countdown_timer_bank_unit.sv -----
// countdown_timer_bank_unit: top level of the frame-counted timer bank
// joins ctb_ctrl and ctb_datapath; depends on ctb_pkg
//
// usage:
// - request channel in_valid_i / in_ready_o carries one beat per operation:
//   tick, create, start, stop, pause or unpause; one request is worked at a time
// - result channel out_valid_o / out_ready_i: a create gives one reply beat,
//   a tick gives one expiry beat per timer that runs out, last_o on the final one,
//   and a tick with no expiry, like start/stop/pause/unpause, gives no beat
// - the frame rate register is written through cfg_we_i / cfg_wdata_i; the user must
//   write it only while idle, the block itself does not enforce this
// - a tick walks over the slots one slot per cycle unless the output stalls it;
//   a create searches the slots for a free one, forms the millisecond product, then
//   divides by 1000 with the reciprocal multiply
// - throughput: the next request is taken once the current one is done
// - the output register holds a finished beat, so a new request is accepted
//   while the last result still waits; when the receiver stalls during a tick
//   the walk holds at an expiring slot behind a pending one until the output frees
// - reset: all timers stopped with zero count, all slots free, rate 60
`timescale 1ns / 1ps
`default_nettype none

module countdown_timer_bank_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ctb_pkg::FPS_W-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ctb_pkg::OP_W-1:0]    operation_i,
  input  wire logic [ctb_pkg::ID_W-1:0]    timer_id_i,
  input  wire logic [ctb_pkg::MS_W-1:0]    time_ms_i,
  input  wire logic [ctb_pkg::ENT_W-1:0]   entity_i,
  input  wire logic [ctb_pkg::TYPE_W-1:0]  timeout_type_i,
  input  wire logic                        is_subtimer_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             result_kind_o,
  output logic [ctb_pkg::ID_W-1:0]         slot_id_o,
  output logic                             create_ok_o,
  output logic [ctb_pkg::ENT_W-1:0]        owner_o,
  output logic [ctb_pkg::TYPE_W-1:0]       kind_of_timeout_o,
  output logic                             sub_mark_o,
  output logic                             last_o
);

  ctb_pkg::cmd_t    cmd;
  ctb_pkg::stat_t   stat;
  ctb_pkg::result_t res;

  // sequencer
  ctb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // timer storage and arithmetic
  ctb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .timer_id_i     (timer_id_i),
    .time_ms_i      (time_ms_i),
    .entity_i       (entity_i),
    .timeout_type_i (timeout_type_i),
    .is_subtimer_i  (is_subtimer_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_res_o      (res)
  );

  // result fields
  assign result_kind_o     = res.result_kind;
  assign slot_id_o         = res.slot_id;
  assign create_ok_o       = res.create_ok;
  assign owner_o           = res.msg.owner;
  assign kind_of_timeout_o = res.msg.kind_of_timeout;
  assign sub_mark_o        = res.msg.sub_mark;
  assign last_o            = res.last;

endmodule

`default_nettype wire
